// File: rtl/core/assert_macros.svh
// Assertion helpers for the container checker.
// Build with NO_ASSERTIONS defined to drop every check.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property must hold at every clock edge outside reset.
`define JCC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define JCC_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`else

`define JCC_ASSERT(lbl, clk, rstn, prop, msg)
`define JCC_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

// File: rtl/core/jcc_pkg.sv
`default_nettype none

package jcc_pkg;

    // Offset counter width; byte count saturates at all ones.
    localparam int OFFSET_BITS = 32;
    localparam int OFF_W       = OFFSET_BITS;
    // Walk target may run one bit past the offset range.
    localparam int TGT_W       = OFFSET_BITS + 1;
    // Width for verdict arithmetic: covers target range and 32-bit registers.
    localparam int XW          = (OFFSET_BITS + 1 > 33) ? OFFSET_BITS + 1 : 33;

    localparam int REG_ADDR_W  = 4;

    typedef logic [1:0] reg_idx_t;
    localparam reg_idx_t REG_CHECK_INTEGRITY = 2'd0;
    localparam reg_idx_t REG_MAX_EXTRA_BYTES = 2'd1;
    localparam reg_idx_t REG_WALK_LIMIT      = 2'd2;
    localparam reg_idx_t REG_EOI_WINDOW      = 2'd3;

    localparam logic        CHECK_INTEGRITY_RST = 1'b1;
    localparam logic [31:0] MAX_EXTRA_RST       = 32'd0;
    localparam logic [15:0] WALK_LIMIT_RST      = 16'd1000;
    localparam logic [15:0] EOI_WINDOW_RST      = 16'd20;

    localparam logic [7:0] BYTE_FF  = 8'hFF;
    localparam logic [7:0] BYTE_00  = 8'h00;
    localparam logic [7:0] BYTE_EOI = 8'hD9;
    localparam logic [7:0] BYTE_RST_LO = 8'hD0;
    localparam logic [7:0] BYTE_RST_HI = 8'hD7;

    localparam logic [1:0] STATUS_VALID   = 2'd0;
    localparam logic [1:0] STATUS_NO_EOI  = 2'd1;
    localparam logic [1:0] STATUS_BAD_LEN = 2'd2;

    typedef enum logic [2:0] {
        WALK_SKIP,
        WALK_SEG,
        WALK_MARKER,
        WALK_LEN_HI,
        WALK_LEN_LO,
        WALK_DONE
    } walk_mode_t;

    typedef struct packed {
        logic        check_integrity;
        logic [31:0] max_extra_bytes;
        logic [15:0] walk_limit;
        logic [15:0] eoi_window;
    } cfg_t;

    // End-of-file picture of the scan state, handed to the verdict logic.
    typedef struct packed {
        logic [OFF_W-1:0] n;
        logic             eoi_found;
        logic [OFF_W-1:0] eoi_start;
        logic             in_seg;
        logic [TGT_W-1:0] walk_target;
        logic             length_error;
        logic [OFF_W-1:0] marker_offset;
        logic [15:0]      segment_length;
    } snap_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] bad_marker_offset;
        logic [15:0] bad_length;
        logic        appended_flag;
        logic [31:0] appended_bytes;
        logic [31:0] real_image_size;
    } result_t;

    function automatic logic [31:0] fit32(input logic [XW-1:0] v);
        return v[31:0];
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/jcc_scan.sv
`default_nettype none

module jcc_scan import jcc_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       en,
    input  wire logic       in_valid,
    input  wire logic [7:0] in_byte,
    input  wire logic       in_last,
    input  wire cfg_t       cfg,
    output logic            snap_valid,
    output snap_t           snap
);

    logic [OFF_W-1:0] byte_count_reg,    byte_count_next;
    logic [7:0]       previous_byte_reg;
    logic             eoi_found_reg,     eoi_found_next;
    logic [OFF_W-1:0] eoi_start_reg,     eoi_start_next;
    walk_mode_t       walk_mode_reg,     walk_mode_next;
    logic [TGT_W-1:0] walk_target_reg,   walk_target_next;
    logic [OFF_W-1:0] marker_offset_reg, marker_offset_next;
    logic [15:0]      segment_length_reg, segment_length_next;
    logic             length_error_reg,  length_error_next;

    logic             snap_valid_reg;
    snap_t            snap_reg, snap_next;

    logic [OFF_W-1:0] off;
    logic             pos_stop;
    logic             at_target;

    always_comb begin
        off       = byte_count_reg;
        pos_stop  = (off >= OFF_W'(cfg.walk_limit)) || (in_byte != BYTE_FF);
        at_target = (TGT_W'(off) == walk_target_reg);

        eoi_found_next      = eoi_found_reg;
        eoi_start_next      = eoi_start_reg;
        walk_mode_next      = walk_mode_reg;
        walk_target_next    = walk_target_reg;
        marker_offset_next  = marker_offset_reg;
        segment_length_next = segment_length_reg;
        length_error_next   = length_error_reg;

        if ((off != '0) && (previous_byte_reg == BYTE_FF) && (in_byte == BYTE_EOI)) begin
            eoi_found_next = 1'b1;
            eoi_start_next = off - OFF_W'(1);
        end

        case (walk_mode_reg)
            WALK_SKIP, WALK_SEG: begin
                if (at_target) begin
                    if (pos_stop) begin
                        walk_mode_next = WALK_DONE;
                    end else begin
                        marker_offset_next = off;
                        walk_mode_next     = WALK_MARKER;
                    end
                end
            end
            WALK_MARKER: begin
                if ((in_byte == BYTE_EOI) || (in_byte == BYTE_00)) begin
                    walk_mode_next = WALK_DONE;
                end else if (in_byte == BYTE_FF) begin
                    // fill byte: FF re-enters at this offset
                    if (pos_stop) begin
                        walk_mode_next = WALK_DONE;
                    end else begin
                        marker_offset_next = off;
                    end
                end else if (in_byte inside {[BYTE_RST_LO:BYTE_RST_HI]}) begin
                    walk_target_next = TGT_W'(marker_offset_reg) + TGT_W'(2);
                    walk_mode_next   = WALK_SKIP;
                end else begin
                    walk_mode_next = WALK_LEN_HI;
                end
            end
            WALK_LEN_HI: begin
                segment_length_next = {in_byte, 8'h00};
                walk_mode_next      = WALK_LEN_LO;
            end
            WALK_LEN_LO: begin
                segment_length_next = {segment_length_reg[15:8], in_byte};
                if (segment_length_next < 16'd2) begin
                    length_error_next = 1'b1;
                    walk_mode_next    = WALK_DONE;
                end else begin
                    walk_target_next = TGT_W'(marker_offset_reg) + TGT_W'(2)
                                     + TGT_W'(segment_length_next);
                    walk_mode_next   = WALK_SEG;
                end
            end
            default: begin
                walk_mode_next = walk_mode_reg;
            end
        endcase

        byte_count_next = (off != {OFF_W{1'b1}}) ? off + OFF_W'(1) : off;

        snap_next.n              = byte_count_next;
        snap_next.eoi_found      = eoi_found_next;
        snap_next.eoi_start      = eoi_start_next;
        snap_next.in_seg         = (walk_mode_next == WALK_SEG);
        snap_next.walk_target    = walk_target_next;
        snap_next.length_error   = length_error_next;
        snap_next.marker_offset  = marker_offset_next;
        snap_next.segment_length = segment_length_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg     <= '0;
            previous_byte_reg  <= '0;
            eoi_found_reg      <= 1'b0;
            eoi_start_reg      <= '0;
            walk_mode_reg      <= WALK_SKIP;
            walk_target_reg    <= TGT_W'(2);
            marker_offset_reg  <= '0;
            segment_length_reg <= '0;
            length_error_reg   <= 1'b0;
        end else if (en && in_valid) begin
            if (in_last) begin
                // file done: back to the start-of-file state
                byte_count_reg     <= '0;
                previous_byte_reg  <= '0;
                eoi_found_reg      <= 1'b0;
                eoi_start_reg      <= '0;
                walk_mode_reg      <= WALK_SKIP;
                walk_target_reg    <= TGT_W'(2);
                marker_offset_reg  <= '0;
                segment_length_reg <= '0;
                length_error_reg   <= 1'b0;
            end else begin
                byte_count_reg     <= byte_count_next;
                previous_byte_reg  <= in_byte;
                eoi_found_reg      <= eoi_found_next;
                eoi_start_reg      <= eoi_start_next;
                walk_mode_reg      <= walk_mode_next;
                walk_target_reg    <= walk_target_next;
                marker_offset_reg  <= marker_offset_next;
                segment_length_reg <= segment_length_next;
                length_error_reg   <= length_error_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            snap_valid_reg <= 1'b0;
        end else if (en) begin
            snap_valid_reg <= in_valid && in_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            snap_reg <= snap_next;
        end
    end

    assign snap_valid = snap_valid_reg;
    assign snap       = snap_reg;

endmodule

`default_nettype wire

// File: rtl/core/jcc_verdict.sv
`default_nettype none

module jcc_verdict import jcc_pkg::*; (
    input  wire snap_t   snap,
    input  wire cfg_t    cfg,
    output result_t      res
);

    logic [XW-1:0] n_x;
    logic [XW-1:0] start_x;
    logic [XW-1:0] win_end;
    logic [XW-1:0] eoi_end;
    logic [XW-1:0] extra;
    logic          missing;
    logic          tail_short;
    logic          bad_len;
    logic          app;

    always_comb begin
        n_x     = XW'(snap.n);
        start_x = XW'(snap.eoi_start);
        win_end = start_x + XW'(cfg.eoi_window);
        eoi_end = start_x + XW'(2);
        extra   = n_x - eoi_end;

        missing    = !((n_x >= XW'(2)) && snap.eoi_found && (win_end >= n_x));
        // file ended before the last segment's body did
        tail_short = snap.in_seg && (n_x < XW'(snap.walk_target));
        bad_len    = snap.length_error || tail_short;
        app        = snap.eoi_found && (eoi_end < n_x) && (extra > XW'(cfg.max_extra_bytes));

        res = '0;
        if (missing) begin
            res.status = STATUS_NO_EOI;
        end else if (bad_len) begin
            res.status            = STATUS_BAD_LEN;
            res.bad_marker_offset = fit32(XW'(snap.marker_offset));
            res.bad_length        = snap.segment_length;
        end else begin
            res.status = STATUS_VALID;
        end

        if (cfg.check_integrity) begin
            if (snap.eoi_found) begin
                res.appended_flag   = app;
                res.appended_bytes  = app ? fit32(extra) : 32'd0;
                res.real_image_size = fit32(eoi_end);
            end else begin
                res.real_image_size = fit32(n_x);
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/jpeg_container_checker.sv
// Channel   Ports                                   Moves
// s_        s_valid s_ready s_data_byte s_last      one file byte per item
// m_        m_valid m_ready m_status ... m_real_..  one verdict per file
// apb       psel penable pwrite paddr pwdata prdata  config registers, 4-byte stride
//
// One byte per cycle while s_ready is high; the scan state update is the
// single-cycle loop. Verdicts pass the input, snapshot and result registers.
// aresetn is synchronous, active low; reset values load at the clock edge.
// A held m_ item stalls the pipe only once a second verdict waits behind it in the
// snapshot stage; s_ready drops only then.
// No clearing pass: ready for bytes in the cycle after reset.
`default_nettype none
`include "assert_macros.svh"

module jpeg_container_checker import jcc_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [7:0]            s_data_byte,
    input  wire logic                  s_last,

    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [1:0]                 m_status,
    output logic [31:0]                m_bad_marker_offset,
    output logic [15:0]                m_bad_length,
    output logic                       m_appended_flag,
    output logic [31:0]                m_appended_bytes,
    output logic [31:0]                m_real_image_size,

    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [REG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    // ---- configuration registers ----
    logic        check_integrity_reg;
    logic [31:0] max_extra_bytes_reg;
    logic [15:0] walk_limit_reg;
    logic [15:0] eoi_window_reg;
    cfg_t        cfg;
    reg_idx_t    reg_idx;
    logic        cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = paddr[REG_ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            check_integrity_reg <= CHECK_INTEGRITY_RST;
            max_extra_bytes_reg <= MAX_EXTRA_RST;
            walk_limit_reg      <= WALK_LIMIT_RST;
            eoi_window_reg      <= EOI_WINDOW_RST;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_CHECK_INTEGRITY: check_integrity_reg <= pwdata[0];
                REG_MAX_EXTRA_BYTES: max_extra_bytes_reg <= pwdata;
                REG_WALK_LIMIT:      walk_limit_reg      <= pwdata[15:0];
                REG_EOI_WINDOW:      eoi_window_reg      <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_CHECK_INTEGRITY: prdata = {31'd0, check_integrity_reg};
            REG_MAX_EXTRA_BYTES: prdata = max_extra_bytes_reg;
            REG_WALK_LIMIT:      prdata = {16'd0, walk_limit_reg};
            REG_EOI_WINDOW:      prdata = {16'd0, eoi_window_reg};
            default:             prdata = 32'd0;
        endcase
    end

    assign cfg.check_integrity = check_integrity_reg;
    assign cfg.max_extra_bytes = max_extra_bytes_reg;
    assign cfg.walk_limit      = walk_limit_reg;
    assign cfg.eoi_window      = eoi_window_reg;

    // ---- pipe control ----
    // The result register takes a verdict when free or being emptied. The
    // front stages keep moving unless a verdict sits in the snapshot stage
    // and the result register cannot take it.
    logic adv;
    logic m_adv;
    logic m_valid_reg;
    logic snap_valid;

    assign m_adv   = !m_valid_reg || m_ready;
    assign adv     = m_adv || !snap_valid;
    assign s_ready = adv;

    // ---- input register ----
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (adv) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && s_valid) begin
            in_byte_reg <= s_data_byte;
            in_last_reg <= s_last;
        end
    end

    // ---- scan: EOI tracking and marker walk, snapshot on final byte ----
    snap_t snap;

    jcc_scan u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (adv),
        .in_valid   (in_valid_reg),
        .in_byte    (in_byte_reg),
        .in_last    (in_last_reg),
        .cfg        (cfg),
        .snap_valid (snap_valid),
        .snap       (snap)
    );

    // ---- verdict and result register ----
    result_t res_next;
    result_t res_reg;

    jcc_verdict u_verdict (
        .snap (snap),
        .cfg  (cfg),
        .res  (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (m_adv) begin
            m_valid_reg <= snap_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_adv && snap_valid) begin
            res_reg <= res_next;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_status            = res_reg.status;
    assign m_bad_marker_offset = res_reg.bad_marker_offset;
    assign m_bad_length        = res_reg.bad_length;
    assign m_appended_flag     = res_reg.appended_flag;
    assign m_appended_bytes    = res_reg.appended_bytes;
    assign m_real_image_size   = res_reg.real_image_size;

    // ---- checks ----
    `JCC_NEVER(a_status_code, aclk, aresetn, m_valid && (m_status == 2'd3), "status out of range")
    `JCC_ASSERT(a_bad_fields, aclk, aresetn, (m_valid && (m_status != STATUS_BAD_LEN)) |-> ((m_bad_length == 16'd0) && (m_bad_marker_offset == 32'd0)), "bad-length fields set without bad-length status")
    `JCC_ASSERT(a_appended, aclk, aresetn, (m_valid && !m_appended_flag) |-> (m_appended_bytes == 32'd0), "appended count without flag")
    `JCC_ASSERT(a_last_to_snap, aclk, aresetn, (in_valid_reg && in_last_reg && adv) |=> snap_valid, "final byte lost before verdict")

endmodule

`default_nettype wire

// File: test/tb_jpeg_container_checker.sv
module tb_jpeg_container_checker;
    import jcc_pkg::*;

    // Marker codes used to build files, beyond those the package names.
    localparam logic [7:0] MK_SOI  = 8'hD8;
    localparam logic [7:0] MK_SOS  = 8'hDA;
    localparam logic [7:0] MK_DQT  = 8'hDB;
    localparam logic [7:0] MK_APP0 = 8'hE0;
    localparam logic [7:0] MK_APP1 = 8'hE1;
    localparam logic [7:0] MK_COM  = 8'hFE;

    // Room for the verdict to pass the input, snapshot and result registers, with slack on top.
    localparam int DRAIN_CYCLES   = 4;
    // Longest quiet stretch in a good run is one source gap or sink stall at
    // 81 % per cycle, plus the passage through the pipeline registers. Far beyond that is a hang.
    localparam int QUIET_LIMIT    = 5000;
    localparam int PHASE_BYTES    = 180;
    localparam int RANDOM_PHASES  = 8;
    localparam int PRINT_LIMIT    = 50;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;

    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte = 8'h00;
    logic        s_last = 1'b0;

    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_status;
    logic [31:0] m_bad_marker_offset;
    logic [15:0] m_bad_length;
    logic        m_appended_flag;
    logic [31:0] m_appended_bytes;
    logic [31:0] m_real_image_size;

    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [REG_ADDR_W-1:0] paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;

    jpeg_container_checker dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_data_byte         (s_data_byte),
        .s_last              (s_last),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_status            (m_status),
        .m_bad_marker_offset (m_bad_marker_offset),
        .m_bad_length        (m_bad_length),
        .m_appended_flag     (m_appended_flag),
        .m_appended_bytes    (m_appended_bytes),
        .m_real_image_size   (m_real_image_size),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready)
    );

    always #6 aclk = ~aclk;

    // Shadow of the register file and of the scan state.
    cfg_t        shadow_cfg;
    logic [63:0] pos_count;
    logic [7:0]  prev_byte;
    logic        eoi_seen;
    logic [63:0] eoi_at;
    walk_mode_t  walk_st;
    logic [63:0] walk_tgt;
    logic [63:0] mark_off;
    logic [15:0] seg_len;
    logic        len_err;

    result_t     verdict_q[$];
    logic [7:0]  file_bytes[$];

    int src_idle_pct = 0;
    int rx_stall_pct = 0;
    int err_cnt = 0;
    int quiet_cycles = 0;
    int bytes_taken = 0;
    int files_sent = 0;
    int verdicts_seen = 0;
    int regs_written = 0;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (err_cnt < PRINT_LIMIT)
            $display("[%0t] MISMATCH %s: got %0h, wanted %0h (verdict %0d)",
                     $realtime, what, got, want, verdicts_seen);
        err_cnt++;
    endtask

    // ------------------------------------------------------------------
    // Scan predictor
    // ------------------------------------------------------------------
    function automatic void clear_scan();
        pos_count = '0;
        prev_byte = '0;
        eoi_seen  = 1'b0;
        eoi_at    = '0;
        walk_st   = WALK_SKIP;
        walk_tgt  = 64'd2;
        mark_off  = '0;
        seg_len   = '0;
        len_err   = 1'b0;
    endfunction

    // Walk has just landed on a new position whose byte is b.
    function automatic void enter_walk_pos(input logic [63:0] off, input logic [7:0] b);
        if (off >= shadow_cfg.walk_limit || b != BYTE_FF) begin
            walk_st = WALK_DONE;
        end else begin
            mark_off = off;
            walk_st  = WALK_MARKER;
        end
    endfunction

    // One accepted byte; on the final byte the verdict is queued.
    function automatic void scan_byte(input logic [7:0] b, input logic lst);
        logic [63:0] off;
        logic [63:0] n;
        logic [63:0] endp;
        result_t     want;

        off = pos_count;
        if (off >= 1 && prev_byte == BYTE_FF && b == BYTE_EOI) begin
            eoi_seen = 1'b1;
            eoi_at   = off - 1;
        end

        case (walk_st)
            WALK_SKIP, WALK_SEG: begin
                if (off == walk_tgt)
                    enter_walk_pos(off, b);
            end
            WALK_MARKER: begin
                if (b == BYTE_EOI || b == BYTE_00) begin
                    walk_st = WALK_DONE;
                end else if (b == BYTE_FF) begin
                    enter_walk_pos(off, b);
                end else if (b >= BYTE_RST_LO && b <= BYTE_RST_HI) begin
                    walk_tgt = mark_off + 2;
                    walk_st  = WALK_SKIP;
                end else begin
                    walk_st = WALK_LEN_HI;
                end
            end
            WALK_LEN_HI: begin
                seg_len = {b, 8'h00};
                walk_st = WALK_LEN_LO;
            end
            WALK_LEN_LO: begin
                seg_len[7:0] = b;
                if (seg_len < 2) begin
                    len_err = 1'b1;
                    walk_st = WALK_DONE;
                end else begin
                    walk_tgt = mark_off + 2 + seg_len;
                    walk_st  = WALK_SEG;
                end
            end
            default: ;
        endcase

        prev_byte = b;
        if (pos_count < 64'hFFFF_FFFF)
            pos_count++;

        if (!lst)
            return;

        n = pos_count;
        // a segment still open at the end ran past the file
        if (walk_st == WALK_SEG && n < walk_tgt)
            len_err = 1'b1;

        want        = '0;
        want.status = STATUS_VALID;
        if (!(n >= 2 && eoi_seen && eoi_at + shadow_cfg.eoi_window >= n)) begin
            want.status = STATUS_NO_EOI;
        end else if (len_err) begin
            want.status            = STATUS_BAD_LEN;
            want.bad_marker_offset = mark_off[31:0];
            want.bad_length        = seg_len;
        end

        if (shadow_cfg.check_integrity) begin
            if (eoi_seen) begin
                endp = eoi_at + 2;
                if (endp < n && n - endp > shadow_cfg.max_extra_bytes) begin
                    want.appended_flag  = 1'b1;
                    want.appended_bytes = 32'(n - endp);
                end
                want.real_image_size = endp[31:0];
            end else begin
                want.real_image_size = n[31:0];
            end
        end

        verdict_q.push_back(want);
        clear_scan();
    endfunction

    task automatic check_verdict(input result_t want);
        verdicts_seen++;
        if (m_status !== want.status)
            report_mismatch("status", 32'(m_status), 32'(want.status));
        if (m_bad_marker_offset !== want.bad_marker_offset)
            report_mismatch("bad_marker_offset", m_bad_marker_offset, want.bad_marker_offset);
        if (m_bad_length !== want.bad_length)
            report_mismatch("bad_length", 32'(m_bad_length), 32'(want.bad_length));
        if (m_appended_flag !== want.appended_flag)
            report_mismatch("appended_flag", 32'(m_appended_flag), 32'(want.appended_flag));
        if (m_appended_bytes !== want.appended_bytes)
            report_mismatch("appended_bytes", m_appended_bytes, want.appended_bytes);
        if (m_real_image_size !== want.real_image_size)
            report_mismatch("real_image_size", m_real_image_size, want.real_image_size);
    endtask

    // Both channels sampled at the edge: verdict first, then the byte, so a
    // verdict leaving and a new file's last byte arriving keep their order.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (verdict_q.size() == 0)
                    report_mismatch("verdict with nothing pending", 32'd0, 32'd0);
                else
                    check_verdict(verdict_q.pop_front());
            end
            if (s_valid && s_ready) begin
                scan_byte(s_data_byte, s_last);
                bytes_taken++;
            end
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
    end

    // Sink: random back-pressure at the phase's stall rate.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // Watchdog on cycles in which no item moves on either channel.
    initial begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge aclk);
        $display("no progress for %0d cycles", QUIET_LIMIT);
        $display("jpeg_container_checker test failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    // Register write, then read back; only the register's own bits compared.
    task automatic cfg_write(input reg_idx_t idx, input logic [31:0] val);
        logic [31:0] mask;

        case (idx)
            REG_CHECK_INTEGRITY: mask = 32'h0000_0001;
            REG_MAX_EXTRA_BYTES: mask = 32'hFFFF_FFFF;
            default:             mask = 32'h0000_FFFF;
        endcase

        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        case (idx)
            REG_CHECK_INTEGRITY: shadow_cfg.check_integrity = val[0];
            REG_MAX_EXTRA_BYTES: shadow_cfg.max_extra_bytes = val;
            REG_WALK_LIMIT:      shadow_cfg.walk_limit      = val[15:0];
            default:             shadow_cfg.eoi_window      = val[15:0];
        endcase
        regs_written++;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if ((prdata & mask) !== (val & mask))
            report_mismatch("register readback", prdata & mask, val & mask);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // One byte item; valid held until taken, optional gap before it.
    task automatic send_byte(input logic [7:0] b, input logic lst);
        if ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < src_idle_pct);
        end
        s_valid     <= 1'b1;
        s_data_byte <= b;
        s_last      <= lst;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_file();
        foreach (file_bytes[i])
            send_byte(file_bytes[i], i == file_bytes.size() - 1);
        files_sent++;
    endtask

    // Block idle: every verdict back and the pipe empty.
    task automatic wait_idle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (verdict_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Bias towards the bytes the scan cares about.
    function automatic logic [7:0] noisy_byte();
        case ($urandom_range(7))
            0:       return BYTE_FF;
            1:       return BYTE_EOI;
            2:       return BYTE_00;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // Mostly marker-structured files with random content; some noise,
    // bad lengths, overruns, missing EOI, trailing junk and truncation.
    task automatic build_random_file();
        int unsigned roll;
        int unsigned sel;
        int unsigned seglen;
        int unsigned cut;
        logic [7:0]  code;

        file_bytes.delete();
        roll = $urandom_range(99);
        if (roll < 12) begin
            repeat ($urandom_range(1, 30)) file_bytes.push_back(noisy_byte());
        end else begin
            file_bytes.push_back(BYTE_FF);
            file_bytes.push_back(MK_SOI);
            if (roll < 16)
                file_bytes[1] = noisy_byte();
            repeat ($urandom_range(0, 4)) begin
                case ($urandom_range(5))
                    0: file_bytes.push_back(BYTE_FF);   // fill before next marker
                    1: begin
                        file_bytes.push_back(BYTE_FF);
                        file_bytes.push_back(BYTE_RST_LO + 8'($urandom_range(7)));
                    end
                    2: begin
                        // scan header then entropy data; walk lands on data
                        file_bytes.push_back(BYTE_FF);
                        file_bytes.push_back(MK_SOS);
                        file_bytes.push_back(8'h00);
                        file_bytes.push_back(8'h08);
                        repeat (6) file_bytes.push_back(8'($urandom_range(255)));
                        repeat ($urandom_range(0, 12)) file_bytes.push_back(noisy_byte());
                    end
                    default: begin
                        code = 8'($urandom_range(8'hC0, 8'hFE));
                        if ($urandom_range(9) == 0)
                            code = 8'($urandom_range(1, 8'hBF));
                        if ((code >= BYTE_RST_LO && code <= BYTE_RST_HI) || code == BYTE_EOI)
                            code = MK_DQT;
                        sel = $urandom_range(99);
                        if (sel < 8)
                            seglen = $urandom_range(0, 1);
                        else if (sel < 13)
                            seglen = $urandom_range(100, 65535);
                        else if (sel < 15)
                            seglen = $urandom_range(300, 600);
                        else
                            seglen = $urandom_range(2, 14);
                        file_bytes.push_back(BYTE_FF);
                        file_bytes.push_back(code);
                        file_bytes.push_back(seglen[15:8]);
                        file_bytes.push_back(seglen[7:0]);
                        if (sel >= 13)
                            repeat (seglen - 2) file_bytes.push_back(noisy_byte());
                    end
                endcase
            end
            if ($urandom_range(99) < 88) begin
                file_bytes.push_back(BYTE_FF);
                file_bytes.push_back(BYTE_EOI);
            end
            sel = $urandom_range(99);
            if (sel < 25)
                repeat ($urandom_range(1, 6)) file_bytes.push_back(noisy_byte());
            else if (sel < 30)
                repeat ($urandom_range(20, 50)) file_bytes.push_back(noisy_byte());
        end
        if (file_bytes.size() > 1 && $urandom_range(99) < 8) begin
            cut = $urandom_range(1, file_bytes.size() - 1);
            file_bytes = file_bytes[0:cut-1];
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Runs on reset register values.
    task automatic test_directed_files();
        // a single byte: too short for any EOI
        file_bytes = '{BYTE_FF};
        send_file();
        // length field below two
        file_bytes = '{BYTE_FF, MK_SOI, BYTE_FF, MK_APP0, 8'h00, 8'h01, BYTE_FF, BYTE_EOI};
        send_file();
        // segment claims more bytes than the file holds
        file_bytes = '{BYTE_FF, MK_SOI, BYTE_FF, MK_COM, 8'h00, 8'h10, BYTE_FF, BYTE_EOI};
        send_file();
        // fill FF, restart marker, SOI read as a length marker, one byte after EOI
        file_bytes = '{BYTE_FF, MK_SOI, BYTE_FF, BYTE_FF, BYTE_RST_LO, BYTE_FF, MK_SOI,
                       8'h00, 8'h02, BYTE_FF, BYTE_EOI, BYTE_00};
        send_file();
        // EOI inside a payload, file stops in the next length field
        file_bytes = '{BYTE_FF, MK_SOI, BYTE_FF, MK_APP0, 8'h00, 8'h04, BYTE_FF, BYTE_EOI,
                       BYTE_FF, MK_APP1, 8'h00};
        send_file();
        wait_idle();
    endtask

    // Window below two and walk limit at or under two; high bits of pwdata ignored.
    task automatic test_register_corners();
        file_bytes = '{BYTE_FF, MK_SOI, BYTE_FF, BYTE_EOI};
        cfg_write(REG_EOI_WINDOW, 32'd0);
        send_file();
        wait_idle();
        cfg_write(REG_EOI_WINDOW, 32'd1);
        send_file();
        wait_idle();
        cfg_write(REG_EOI_WINDOW, 32'hFFFF_0014);
        file_bytes = '{BYTE_FF, MK_SOI, BYTE_FF, MK_APP0, 8'h00, 8'h01, BYTE_FF, BYTE_EOI};
        cfg_write(REG_WALK_LIMIT, 32'h5A5A_0002);
        send_file();
        wait_idle();
        cfg_write(REG_WALK_LIMIT, 32'd0);
        send_file();
        wait_idle();
        cfg_write(REG_WALK_LIMIT, {16'd0, WALK_LIMIT_RST});
    endtask

    // Phases alternate idling style and register setting, extremes first.
    task automatic test_random_files();
        int          phase_bytes;
        logic [31:0] ci;
        logic [31:0] mx;
        logic [31:0] wl;
        logic [31:0] win;

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0: begin
                    ci = 32'd1; mx = 32'd0; wl = 32'd1000; win = 32'd20;
                end
                1: begin
                    ci = 32'd0; mx = 32'hFFFF_FFFF; wl = 32'd3; win = 32'd2;
                end
                2: begin
                    ci = 32'd1; mx = $urandom_range(0, 3); wl = 32'hFFFF; win = 32'hFFFF;
                end
                3: begin
                    ci = 32'd1; mx = 32'hFFFF_FFFF;
                    wl = $urandom_range(3, 40); win = $urandom_range(2, 30);
                end
                default: begin
                    ci  = $urandom;
                    mx  = ($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 6);
                    wl  = ($urandom_range(3) == 0) ? $urandom_range(3, 65535)
                                                   : $urandom_range(3, 120);
                    win = ($urandom_range(5) == 0) ? $urandom_range(2, 65535)
                                                   : $urandom_range(2, 64);
                end
            endcase
            cfg_write(REG_CHECK_INTEGRITY, ci);
            cfg_write(REG_MAX_EXTRA_BYTES, mx);
            cfg_write(REG_WALK_LIMIT, wl);
            cfg_write(REG_EOI_WINDOW, win);

            src_idle_pct = (ph % 4 == 1) ? 81 : (ph % 4 == 3) ? 15 : 0;
            rx_stall_pct = (ph % 4 == 2) ? 81 : (ph % 4 == 3) ? 15 : 0;

            phase_bytes = 0;
            while (phase_bytes < PHASE_BYTES) begin
                build_random_file();
                phase_bytes += file_bytes.size();
                send_file();
            end
            wait_idle();
        end
        src_idle_pct = 0;
        rx_stall_pct = 0;
    endtask

    initial begin
        shadow_cfg.check_integrity = CHECK_INTEGRITY_RST;
        shadow_cfg.max_extra_bytes = MAX_EXTRA_RST;
        shadow_cfg.walk_limit      = WALK_LIMIT_RST;
        shadow_cfg.eoi_window      = EOI_WINDOW_RST;
        clear_scan();

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_files();
        test_register_corners();
        test_random_files();

        $display("Covered %0d files, %0d bytes, %0d verdicts checked, %0d register writes",
                 files_sent, bytes_taken, verdicts_seen, regs_written);
        $display("Traffic: no idling, sparse source, stalled sink, light idling on both");
        if (err_cnt == 0 && verdict_q.size() == 0)
            $display("jpeg_container_checker test passed");
        else
            $display("jpeg_container_checker test failed");
        $finish;
    end

endmodule
